// ----- src/convex_polygon_sat_collision_macros.svh -----
// Assertion helpers shared by the collision block modules.
// All assume a clock named clk_i and an active-low reset named rst_ni.
`ifndef CONVEX_POLYGON_SAT_COLLISION_MACROS_SVH
`define CONVEX_POLYGON_SAT_COLLISION_MACROS_SVH

// Same-cycle implication.
`define CPSC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CPSC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/cpsc_pkg.sv -----
package cpsc_pkg;

  localparam int MaxVerticesDef = 16;
  localparam int CoordBitsDef   = 16;
  localparam int FieldW         = 16;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_EDGE_I,
    ST_EDGE_J,
    ST_EDGE_W,
    ST_PROJ,
    ST_DRAIN,
    ST_CHECK,
    ST_FINISH
  } ctrl_state_e;

  typedef struct packed {
    logic load;
    logic start_test;
    logic hit_clr;
    logic hit_set;
    logic edge_rd_j;
    logic vi_cap;
    logic axis_cap;
    logic proj_issue;
    logic next_axis;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic a_zero;
    logic pipe_busy;
    logic proj_last;
    logic axes_last;
    logic overlap;
    logic out_free;
  } dp_status_t;

endpackage

// ----- src/cpsc_ctrl.sv -----
`include "convex_polygon_sat_collision_macros.svh"

module cpsc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                which_polygon_i,
  input  logic                last_vertex_i,
  output logic                in_ready_o,
  input  cpsc_pkg::dp_status_t status_i,
  output cpsc_pkg::dp_cmd_t   cmd_o
);

  cpsc_pkg::ctrl_state_e state_q, state_d;
  logic                  accept;
  logic                  start_test;

  assign accept     = in_valid_i && (state_q == cpsc_pkg::ST_IDLE);
  assign start_test = accept && which_polygon_i && last_vertex_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cpsc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      cpsc_pkg::ST_IDLE: begin
        if (start_test) state_d = cpsc_pkg::ST_START;
      end
      cpsc_pkg::ST_START: begin
        state_d = status_i.a_zero ? cpsc_pkg::ST_FINISH : cpsc_pkg::ST_EDGE_I;
      end
      cpsc_pkg::ST_EDGE_I: state_d = cpsc_pkg::ST_EDGE_J;
      cpsc_pkg::ST_EDGE_J: state_d = cpsc_pkg::ST_EDGE_W;
      cpsc_pkg::ST_EDGE_W: state_d = cpsc_pkg::ST_PROJ;
      cpsc_pkg::ST_PROJ: begin
        if (status_i.proj_last) state_d = cpsc_pkg::ST_DRAIN;
      end
      cpsc_pkg::ST_DRAIN: begin
        if (!status_i.pipe_busy) state_d = cpsc_pkg::ST_CHECK;
      end
      cpsc_pkg::ST_CHECK: begin
        if (!status_i.overlap || status_i.axes_last) begin
          state_d = cpsc_pkg::ST_FINISH;
        end else begin
          state_d = cpsc_pkg::ST_EDGE_I;
        end
      end
      cpsc_pkg::ST_FINISH: begin
        if (status_i.out_free) state_d = cpsc_pkg::ST_IDLE;
      end
      default: state_d = cpsc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.load = accept;
    case (state_q)
      cpsc_pkg::ST_START: begin
        cmd_o.start_test = 1'b1;
        cmd_o.hit_clr    = 1'b1;
      end
      cpsc_pkg::ST_EDGE_J: begin
        cmd_o.edge_rd_j = 1'b1;
        cmd_o.vi_cap    = 1'b1;
      end
      cpsc_pkg::ST_EDGE_W: cmd_o.axis_cap   = 1'b1;
      cpsc_pkg::ST_PROJ:   cmd_o.proj_issue = 1'b1;
      cpsc_pkg::ST_CHECK: begin
        cmd_o.hit_set   = status_i.overlap && status_i.axes_last;
        cmd_o.next_axis = status_i.overlap && !status_i.axes_last;
      end
      cpsc_pkg::ST_FINISH: cmd_o.finish = status_i.out_free;
      default: ;
    endcase
  end

  assign in_ready_o = (state_q == cpsc_pkg::ST_IDLE);

  `CPSC_ASSERT_NXT(a_last_starts, start_test, state_q == cpsc_pkg::ST_START,
                   "last B vertex did not start the test")
  `CPSC_ASSERT_IMP(a_check_drained, state_q == cpsc_pkg::ST_CHECK, !status_i.pipe_busy,
                   "interval check while projections still in flight")

endmodule

// ----- src/cpsc_datapath.sv -----
`include "convex_polygon_sat_collision_macros.svh"

module cpsc_datapath #(
  parameter int MAX_VERTICES = cpsc_pkg::MaxVerticesDef,
  parameter int COORD_BITS   = cpsc_pkg::CoordBitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  cpsc_pkg::dp_cmd_t              cmd_i,
  output cpsc_pkg::dp_status_t           status_o,
  input  logic                           which_polygon_i,
  input  logic [cpsc_pkg::FieldW-1:0]    x_coord_i,
  input  logic [cpsc_pkg::FieldW-1:0]    y_coord_i,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic                           collide_o,
  output logic                           vertex_overflow_o
);

  localparam int CW   = COORD_BITS;
  localparam int AW   = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CNTW = $clog2(MAX_VERTICES + 1);
  localparam int EXTW = (CW > cpsc_pkg::FieldW) ? CW : cpsc_pkg::FieldW;
  localparam int PW   = 2 * CW + 1;
  localparam int DW   = 2 * CW + 2;
  localparam logic [CNTW-1:0] MaxCnt = CNTW'(MAX_VERTICES);

  // Vertex stores and their registered read ports
  logic [2*CW-1:0] mem_a [MAX_VERTICES];
  logic [2*CW-1:0] mem_b [MAX_VERTICES];
  logic [2*CW-1:0] rd_a_q, rd_b_q;
  logic [AW-1:0]   addr_a, addr_b, edge_addr, edge_j;
  logic [EXTW-1:0] x_ext, y_ext;
  logic [2*CW-1:0] wr_data;
  logic            we_a, we_b;

  logic [CNTW-1:0] a_cnt_q, b_cnt_q, edge_n;
  logic            ovf_q;

  logic            edge_poly_q;
  logic [AW-1:0]   edge_idx_q;
  logic            proj_sel_q;
  logic [AW-1:0]   proj_idx_q;
  logic            edge_wrap, proj_a_end;

  logic [2*CW-1:0]       edge_data, proj_data;
  logic signed [CW-1:0]  vi_x_q, vi_y_q, vj_x, vj_y, px, py;
  logic signed [CW:0]    ax_q, ay_q;

  logic                  s1_v_q, s1_sel_q, s1_first_q;
  logic                  s2_v_q, s2_sel_q, s2_first_q;
  logic                  s3_v_q, s3_sel_q, s3_first_q;
  logic signed [PW-1:0]  mx_q, my_q;
  logic signed [DW-1:0]  d_q;
  logic signed [DW-1:0]  alo_q, ahi_q, blo_q, bhi_q;

  logic hit_q, out_valid_q, collide_q, ovf_out_q;

  // Zero-extend the raw field, then keep the low COORD_BITS as two's complement
  assign x_ext   = EXTW'(x_coord_i);
  assign y_ext   = EXTW'(y_coord_i);
  assign wr_data = {y_ext[CW-1:0], x_ext[CW-1:0]};
  assign we_a    = cmd_i.load && !which_polygon_i && (a_cnt_q < MaxCnt);
  assign we_b    = cmd_i.load && which_polygon_i && (b_cnt_q < MaxCnt);

  assign edge_n    = edge_poly_q ? b_cnt_q : a_cnt_q;
  assign edge_wrap = (CNTW'(edge_idx_q) + CNTW'(1)) == edge_n;
  assign edge_j    = edge_wrap ? '0 : edge_idx_q + AW'(1);
  assign edge_addr = cmd_i.edge_rd_j ? edge_j : edge_idx_q;
  assign addr_a    = cmd_i.proj_issue ? proj_idx_q : edge_addr;
  assign addr_b    = cmd_i.proj_issue ? proj_idx_q : edge_addr;
  assign proj_a_end = (CNTW'(proj_idx_q) + CNTW'(1)) == a_cnt_q;

  always_ff @(posedge clk_i) begin
    if (we_a) mem_a[a_cnt_q[AW-1:0]] <= wr_data;
    rd_a_q <= mem_a[addr_a];
  end

  always_ff @(posedge clk_i) begin
    if (we_b) mem_b[b_cnt_q[AW-1:0]] <= wr_data;
    rd_b_q <= mem_b[addr_b];
  end

  // Vertex counts and overflow flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_cnt_q <= '0;
      b_cnt_q <= '0;
      ovf_q   <= 1'b0;
    end else if (cmd_i.finish) begin
      a_cnt_q <= '0;
      b_cnt_q <= '0;
      ovf_q   <= 1'b0;
    end else if (cmd_i.load) begin
      if (we_a) a_cnt_q <= a_cnt_q + CNTW'(1);
      if (we_b) b_cnt_q <= b_cnt_q + CNTW'(1);
      if (!we_a && !we_b) ovf_q <= 1'b1;
    end
  end

  // Axis and projection walk
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_poly_q <= 1'b0;
      edge_idx_q  <= '0;
      proj_sel_q  <= 1'b0;
      proj_idx_q  <= '0;
    end else begin
      if (cmd_i.start_test) begin
        edge_poly_q <= 1'b0;
        edge_idx_q  <= '0;
      end else if (cmd_i.next_axis) begin
        if (edge_wrap) begin
          edge_poly_q <= 1'b1;
          edge_idx_q  <= '0;
        end else begin
          edge_idx_q <= edge_idx_q + AW'(1);
        end
      end
      if (cmd_i.axis_cap) begin
        proj_sel_q <= 1'b0;
        proj_idx_q <= '0;
      end else if (cmd_i.proj_issue) begin
        if (!proj_sel_q && proj_a_end) begin
          proj_sel_q <= 1'b1;
          proj_idx_q <= '0;
        end else begin
          proj_idx_q <= proj_idx_q + AW'(1);
        end
      end
    end
  end

  assign edge_data = edge_poly_q ? rd_b_q : rd_a_q;
  assign vj_x      = edge_data[CW-1:0];
  assign vj_y      = edge_data[2*CW-1:CW];

  always_ff @(posedge clk_i) begin
    if (cmd_i.vi_cap) begin
      vi_x_q <= edge_data[CW-1:0];
      vi_y_q <= edge_data[2*CW-1:CW];
    end
    if (cmd_i.axis_cap) begin
      ax_q <= vi_y_q - vj_y;
      ay_q <= vj_x - vi_x_q;
    end
  end

  // Projection pipeline: read, multiply, sum, min/max
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      s1_v_q <= cmd_i.proj_issue;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
    end
  end

  assign proj_data = s1_sel_q ? rd_b_q : rd_a_q;
  assign px        = proj_data[CW-1:0];
  assign py        = proj_data[2*CW-1:CW];

  always_ff @(posedge clk_i) begin
    s1_sel_q   <= proj_sel_q;
    s1_first_q <= (proj_idx_q == '0);
    s2_sel_q   <= s1_sel_q;
    s2_first_q <= s1_first_q;
    s3_sel_q   <= s2_sel_q;
    s3_first_q <= s2_first_q;
    mx_q       <= px * ax_q;
    my_q       <= py * ay_q;
    d_q        <= mx_q + my_q;
    if (s3_v_q && !s3_sel_q) begin
      if (s3_first_q || d_q < alo_q) alo_q <= d_q;
      if (s3_first_q || d_q > ahi_q) ahi_q <= d_q;
    end
    if (s3_v_q && s3_sel_q) begin
      if (s3_first_q || d_q < blo_q) blo_q <= d_q;
      if (s3_first_q || d_q > bhi_q) bhi_q <= d_q;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.hit_clr) begin
        hit_q <= 1'b0;
      end else if (cmd_i.hit_set) begin
        hit_q <= 1'b1;
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      collide_q <= hit_q;
      ovf_out_q <= ovf_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign collide_o         = collide_q;
  assign vertex_overflow_o = ovf_out_q;

  assign status_o.a_zero    = (a_cnt_q == '0);
  assign status_o.pipe_busy = s1_v_q || s2_v_q || s3_v_q;
  assign status_o.proj_last = proj_sel_q && ((CNTW'(proj_idx_q) + CNTW'(1)) == b_cnt_q);
  assign status_o.axes_last = edge_poly_q && edge_wrap;
  assign status_o.overlap   = (ahi_q > blo_q) && (bhi_q > alo_q);
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  `CPSC_ASSERT_IMP(a_finish_free, cmd_i.finish, !out_valid_q || out_ready_i,
                   "result overwritten while still pending")
  `CPSC_ASSERT_IMP(a_cnt_bound, 1'b1, (a_cnt_q <= MaxCnt) && (b_cnt_q <= MaxCnt),
                   "vertex count beyond capacity")
  `CPSC_ASSERT_NXT(a_proj_flows, cmd_i.proj_issue, s1_v_q,
                   "projection issue lost in the pipeline")

endmodule

// ----- src/convex_polygon_sat_collision.sv -----
// Separating-axis collision test for two convex 2-D polygons.
// Input channel (in_valid_i / in_ready_o): one vertex per transaction, the
// vertices of polygon A (which_polygon_i = 0) first, then those of B. A vertex
// of B with last_vertex_i set closes the pair and starts the test.
// Output channel (out_valid_o / out_ready_i): one transaction per pair, with
// collide_o and vertex_overflow_o (vertices dropped past MAX_VERTICES).
// Throughput: vertices load at one per cycle while idle. After the closing vertex
// in_ready_o drops while the test walks every edge of A, then of B; each
// axis takes edge reads, one projection per cycle through the single
// multiply-add pipeline, a drain and an interval check, and the walk
// stops at the first separating axis.
// The result sits in an output register; if the receiver stalls, a new pair
// can still load, and the next test waits only to post its result.
// Reset clears the vertex counts, the overflow flag and out_valid_o; the
// vertex stores are not cleared, since only written entries are read.
module convex_polygon_sat_collision #(
  parameter int MAX_VERTICES = cpsc_pkg::MaxVerticesDef,
  parameter int COORD_BITS   = cpsc_pkg::CoordBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        which_polygon_i,
  input  logic [cpsc_pkg::FieldW-1:0] x_coord_i,
  input  logic [cpsc_pkg::FieldW-1:0] y_coord_i,
  input  logic                        last_vertex_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        collide_o,
  output logic                        vertex_overflow_o
);

  cpsc_pkg::dp_cmd_t    cmd;
  cpsc_pkg::dp_status_t status;

  // Sequencer: load, edge fetch, projection issue, drain, check, post
  cpsc_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .which_polygon_i (which_polygon_i),
    .last_vertex_i   (last_vertex_i),
    .in_ready_o      (in_ready_o),
    .status_i        (status),
    .cmd_o           (cmd)
  );

  // Vertex stores, axis, projection pipeline and result register
  cpsc_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_BITS   (COORD_BITS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .which_polygon_i   (which_polygon_i),
    .x_coord_i         (x_coord_i),
    .y_coord_i         (y_coord_i),
    .out_ready_i       (out_ready_i),
    .out_valid_o       (out_valid_o),
    .collide_o         (collide_o),
    .vertex_overflow_o (vertex_overflow_o)
  );

endmodule
